// ===== design/wvr_pkg.sv =====
`timescale 1ns / 1ps

package wvr_pkg;

   localparam int DATA_WIDTH_DEF  = 24;
   localparam int ANGLE_WIDTH_DEF = 16;
   localparam int CORDIC_STAGES   = 24;
   localparam int GUARD_BITS      = 8;
   localparam int PHASE_WIDTH     = 34;
   localparam int CSR_ADDR_WIDTH  = 3;
   localparam int CSR_DATA_WIDTH  = 32;

   localparam logic [0:0] REG_TO_EARTH = 1'b0;

   localparam logic [29:0] CORDIC_K = 30'd652032874;

   localparam logic signed [PHASE_WIDTH-1:0] PH_HALF = PHASE_WIDTH'(64'sd1 <<< 30);
   localparam logic signed [PHASE_WIDTH-1:0] PH_PI   = PHASE_WIDTH'(64'sd1 <<< 31);

   localparam logic [31:0] ATAN_TAB [CORDIC_STAGES] = '{
      32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
      32'd42667331,  32'd21354465,  32'd10679838,  32'd5340245,
      32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
      32'd166886,    32'd83443,     32'd41722,     32'd20861,
      32'd10430,     32'd5215,      32'd2608,      32'd1304,
      32'd652,       32'd326,       32'd163,       32'd81
   };

   typedef struct packed {
      logic valid;
      logic last;
   } wvr_tag_type;

endpackage

// ===== design/wvr_gain.sv =====
`timescale 1ns / 1ps

module wvr_gain import wvr_pkg::*; #(
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF,
   localparam int XW = DATA_WIDTH + GUARD_BITS + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          to_earth,
   input  logic                          req_valid,
   input  logic signed [DATA_WIDTH-1:0]  u_in,
   input  logic signed [DATA_WIDTH-1:0]  v_in,
   input  logic signed [ANGLE_WIDTH-1:0] angle,
   input  logic                          last_sample,
   output logic signed [XW-1:0]          x_ff,
   output logic signed [XW-1:0]          y_ff,
   output logic signed [PHASE_WIDTH-1:0] ph_ff,
   output wvr_tag_type                   tag_ff
);

   localparam int PW    = PHASE_WIDTH;
   localparam int PRW   = DATA_WIDTH + 31;
   localparam int SHIFT = 30 - GUARD_BITS;
   localparam logic signed [PRW-1:0] RND_HALF = PRW'(64'sd1 <<< (SHIFT - 1));
   localparam logic signed [30:0]    K_S      = {1'b0, CORDIC_K};

   // stage 0: capture and phase scaling
   logic signed [PW-1:0]         ph_scaled;
   logic signed [PW-1:0]         ph0_in;
   logic signed [DATA_WIDTH-1:0] u0_ff, v0_ff;
   logic signed [PW-1:0]         ph0_ff;
   wvr_tag_type                  tag0_ff;

   // stage 1: gain product
   logic signed [PRW-1:0] pu1_in, pv1_in;
   logic signed [PRW-1:0] pu1_ff, pv1_ff;
   logic signed [PW-1:0]  ph1_ff;
   wvr_tag_type           tag1_ff;

   // stage 2: rounding and quadrant decision
   logic signed [PRW-1:0] ru_sum, rv_sum, ru_sh, rv_sh;
   logic signed [XW-1:0]  x2_in, y2_in;
   logic signed [PW-1:0]  ph2_in;
   logic                  flip2_in;
   logic signed [XW-1:0]  x2_ff, y2_ff;
   logic signed [PW-1:0]  ph2_ff;
   logic                  flip2_ff;
   wvr_tag_type           tag2_ff;

   // stage 3: quadrant fold
   logic signed [XW-1:0] x3_in, y3_in;

   assign ph_scaled = $signed({{(PW - 32){angle[ANGLE_WIDTH-1]}}, angle,
                               {(32 - ANGLE_WIDTH){1'b0}}});
   assign ph0_in    = to_earth ? ph_scaled : -ph_scaled;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
      end else if (en) begin
         tag0_ff <= '{valid: req_valid, last: last_sample};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u0_ff  <= u_in;
         v0_ff  <= v_in;
         ph0_ff <= ph0_in;
      end
   end

   assign pu1_in = u0_ff * K_S;
   assign pv1_in = v0_ff * K_S;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff <= '0;
      end else if (en) begin
         tag1_ff <= tag0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pu1_ff <= pu1_in;
         pv1_ff <= pv1_in;
         ph1_ff <= ph0_ff;
      end
   end

   always_comb begin
      ru_sum = pu1_ff + RND_HALF;
      rv_sum = pv1_ff + RND_HALF;
      ru_sh  = ru_sum >>> SHIFT;
      rv_sh  = rv_sum >>> SHIFT;
      x2_in  = ru_sh[XW-1:0];
      y2_in  = rv_sh[XW-1:0];
      if (ph1_ff > PH_HALF) begin
         ph2_in   = ph1_ff - PH_PI;
         flip2_in = 1'b1;
      end else if (ph1_ff < -PH_HALF) begin
         ph2_in   = ph1_ff + PH_PI;
         flip2_in = 1'b1;
      end else begin
         ph2_in   = ph1_ff;
         flip2_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag2_ff <= '0;
      end else if (en) begin
         tag2_ff <= tag1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x2_ff    <= x2_in;
         y2_ff    <= y2_in;
         ph2_ff   <= ph2_in;
         flip2_ff <= flip2_in;
      end
   end

   assign x3_in = flip2_ff ? -x2_ff : x2_ff;
   assign y3_in = flip2_ff ? -y2_ff : y2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x3_in;
         y_ff  <= y3_in;
         ph_ff <= ph2_ff;
      end
   end

   // folded phase must lie within a quarter turn
   assert property (@(posedge clock) disable iff (reset)
      tag_ff.valid |-> (ph_ff <= PH_HALF && ph_ff >= -PH_HALF))
      else $error("folded phase out of range");

endmodule

// ===== design/wvr_cordic_stage.sv =====
`timescale 1ns / 1ps

module wvr_cordic_stage import wvr_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int STAGE      = 0,
   localparam int XW = DATA_WIDTH + GUARD_BITS + 2
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic signed [XW-1:0]          x_d,
   input  logic signed [XW-1:0]          y_d,
   input  logic signed [PHASE_WIDTH-1:0] ph_d,
   input  wvr_tag_type                   tag_d,
   output logic signed [XW-1:0]          x_ff,
   output logic signed [XW-1:0]          y_ff,
   output logic signed [PHASE_WIDTH-1:0] ph_ff,
   output wvr_tag_type                   tag_ff
);

   localparam logic signed [PHASE_WIDTH-1:0] ATAN = PHASE_WIDTH'(ATAN_TAB[STAGE]);

   logic signed [XW-1:0]          sx, sy;
   logic signed [XW-1:0]          x_in, y_in;
   logic signed [PHASE_WIDTH-1:0] ph_in;
   logic                          ccw;

   always_comb begin
      sx  = x_d >>> STAGE;
      sy  = y_d >>> STAGE;
      ccw = ~ph_d[PHASE_WIDTH-1];
      if (ccw) begin
         x_in  = x_d - sy;
         y_in  = y_d + sx;
         ph_in = ph_d - ATAN;
      end else begin
         x_in  = x_d + sy;
         y_in  = y_d - sx;
         ph_in = ph_d + ATAN;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag_ff <= '0;
      end else if (en) begin
         tag_ff <= tag_d;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff  <= x_in;
         y_ff  <= y_in;
         ph_ff <= ph_in;
      end
   end

endmodule

// ===== design/wvr_out.sv =====
`timescale 1ns / 1ps

module wvr_out import wvr_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   localparam int XW = DATA_WIDTH + GUARD_BITS + 2
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic signed [XW-1:0]         x_d,
   input  logic signed [XW-1:0]         y_d,
   input  wvr_tag_type                  tag_d,
   input  logic                         rsp_stall,
   output logic                         en,
   output logic                         rsp_valid_ff,
   output logic signed [DATA_WIDTH-1:0] u_ff,
   output logic signed [DATA_WIDTH-1:0] v_ff,
   output logic                         last_ff
);

   localparam logic signed [XW:0] OUT_RND = (XW + 1)'(64'sd1 <<< (GUARD_BITS - 1));
   localparam logic signed [XW:0] OUT_MAX = (XW + 1)'((64'sd1 <<< (DATA_WIDTH - 1)) - 1);
   localparam logic signed [XW:0] OUT_MIN = (XW + 1)'(-(64'sd1 <<< (DATA_WIDTH - 1)));

   logic signed [XW:0]         xs, ys, xr, yr;
   logic signed [DATA_WIDTH-1:0] u_sat, v_sat;
   logic                       take;
   logic                       skid_valid_ff;
   logic signed [DATA_WIDTH-1:0] skid_u_ff, skid_v_ff;
   logic                       skid_last_ff;

   always_comb begin
      xs = $signed({x_d[XW-1], x_d}) + OUT_RND;
      ys = $signed({y_d[XW-1], y_d}) + OUT_RND;
      xr = xs >>> GUARD_BITS;
      yr = ys >>> GUARD_BITS;
      if (xr > OUT_MAX) begin
         u_sat = OUT_MAX[DATA_WIDTH-1:0];
      end else if (xr < OUT_MIN) begin
         u_sat = OUT_MIN[DATA_WIDTH-1:0];
      end else begin
         u_sat = xr[DATA_WIDTH-1:0];
      end
      if (yr > OUT_MAX) begin
         v_sat = OUT_MAX[DATA_WIDTH-1:0];
      end else if (yr < OUT_MIN) begin
         v_sat = OUT_MIN[DATA_WIDTH-1:0];
      end else begin
         v_sat = yr[DATA_WIDTH-1:0];
      end
   end

   // pipeline moves whenever the skid slot is free
   assign en   = ~skid_valid_ff;
   assign take = tag_d.valid & en;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (!rsp_stall) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end
      end else if (take) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            rsp_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (!rsp_stall) begin
            u_ff    <= skid_u_ff;
            v_ff    <= skid_v_ff;
            last_ff <= skid_last_ff;
         end
      end else if (take) begin
         if (!rsp_valid_ff || !rsp_stall) begin
            u_ff    <= u_sat;
            v_ff    <= v_sat;
            last_ff <= tag_d.last;
         end else begin
            skid_u_ff    <= u_sat;
            skid_v_ff    <= v_sat;
            skid_last_ff <= tag_d.last;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid word held with empty output register");

   assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && rsp_stall))
      else $error("skid filled without a stalled output word");

   assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !skid_valid_ff))
      else $error("output not empty after reset");

endmodule

// ===== design/wind_vector_rotation_core.sv =====
`timescale 1ns / 1ps

// Rotates one wind word (u, v) per clock by the edge angle, +angle when to_earth is set
// (reset value) and -angle when clear, using a gain-compensated 24-iteration CORDIC with
// rounding and saturation to DATA_WIDTH. The pipeline takes a new word every cycle while
// req_stall is low; it has 29 register stages: 4 gain/fold stages, one per CORDIC
// iteration and one output register. A two-entry output register and skid slot
// sit at the end: req_stall rises only once a stalled output has filled the skid
// slot, and then the whole pipeline holds until the slot drains. to_earth lives at
// address 0 and is applied as words enter, so write it only while the block is empty.

module wind_vector_rotation_core import wvr_pkg::*; #(
   parameter int DATA_WIDTH  = DATA_WIDTH_DEF,
   parameter int ANGLE_WIDTH = ANGLE_WIDTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0]     paddr,
   input  logic [CSR_DATA_WIDTH-1:0]     pwdata,
   output logic [CSR_DATA_WIDTH-1:0]     prdata,
   output logic                          pready,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic signed [DATA_WIDTH-1:0]  req_u_in,
   input  logic signed [DATA_WIDTH-1:0]  req_v_in,
   input  logic signed [ANGLE_WIDTH-1:0] req_angle,
   input  logic                          req_last_sample,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [DATA_WIDTH-1:0]  rsp_u_out,
   output logic signed [DATA_WIDTH-1:0]  rsp_v_out,
   output logic                          rsp_last_out
);

   localparam int XW = DATA_WIDTH + GUARD_BITS + 2;

   logic                 to_earth_ff;
   logic                 csr_hit;
   logic                 en;
   logic signed [XW-1:0]          x_pipe  [CORDIC_STAGES+1];
   logic signed [XW-1:0]          y_pipe  [CORDIC_STAGES+1];
   logic signed [PHASE_WIDTH-1:0] ph_pipe [CORDIC_STAGES+1];
   wvr_tag_type                   tag_pipe[CORDIC_STAGES+1];

   // register file
   assign pready  = 1'b1;
   assign csr_hit = (paddr[CSR_ADDR_WIDTH-1:2] == REG_TO_EARTH);
   assign prdata  = csr_hit ? {{(CSR_DATA_WIDTH - 1){1'b0}}, to_earth_ff} : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         to_earth_ff <= 1'b1;
      end else if (psel && penable && pwrite && pready && csr_hit) begin
         to_earth_ff <= pwdata[0];
      end
   end

   assign req_stall = ~en;

   wvr_gain #(
      .DATA_WIDTH  (DATA_WIDTH),
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_gain (
      .clock       (clock),
      .reset       (reset),
      .en          (en),
      .to_earth    (to_earth_ff),
      .req_valid   (req_valid),
      .u_in        (req_u_in),
      .v_in        (req_v_in),
      .angle       (req_angle),
      .last_sample (req_last_sample),
      .x_ff        (x_pipe[0]),
      .y_ff        (y_pipe[0]),
      .ph_ff       (ph_pipe[0]),
      .tag_ff      (tag_pipe[0])
   );

   for (genvar k = 0; k < CORDIC_STAGES; k++) begin : g_iter
      wvr_cordic_stage #(
         .DATA_WIDTH (DATA_WIDTH),
         .STAGE      (k)
      ) u_stage (
         .clock  (clock),
         .reset  (reset),
         .en     (en),
         .x_d    (x_pipe[k]),
         .y_d    (y_pipe[k]),
         .ph_d   (ph_pipe[k]),
         .tag_d  (tag_pipe[k]),
         .x_ff   (x_pipe[k+1]),
         .y_ff   (y_pipe[k+1]),
         .ph_ff  (ph_pipe[k+1]),
         .tag_ff (tag_pipe[k+1])
      );
   end

   wvr_out #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_out (
      .clock        (clock),
      .reset        (reset),
      .x_d          (x_pipe[CORDIC_STAGES]),
      .y_d          (y_pipe[CORDIC_STAGES]),
      .tag_d        (tag_pipe[CORDIC_STAGES]),
      .rsp_stall    (rsp_stall),
      .en           (en),
      .rsp_valid_ff (rsp_valid),
      .u_ff         (rsp_u_out),
      .v_ff         (rsp_v_out),
      .last_ff      (rsp_last_out)
   );

endmodule

// ===== tb/wind_vector_rotation_core_tb.sv =====
`timescale 1ns / 1ps

module wind_vector_rotation_core_tb;
   import wvr_pkg::*;

   localparam int DW = DATA_WIDTH_DEF;
   localparam int AW = ANGLE_WIDTH_DEF;
   localparam int SPARE_REG = 1;
   localparam logic [CSR_ADDR_WIDTH-1:0] TO_EARTH_ADDR = CSR_ADDR_WIDTH'(4 * REG_TO_EARTH);
   localparam logic [CSR_ADDR_WIDTH-1:0] SPARE_ADDR = CSR_ADDR_WIDTH'(4 * SPARE_REG);
   localparam logic signed [DW-1:0] W_MAX = {1'b0, {(DW-1){1'b1}}};
   localparam logic signed [DW-1:0] W_MIN = {1'b1, {(DW-1){1'b0}}};
   localparam logic signed [AW-1:0] A_MAX = {1'b0, {(AW-1){1'b1}}};
   localparam logic signed [AW-1:0] A_MIN = {1'b1, {(AW-1){1'b0}}};
   localparam logic signed [AW-1:0] A_QUARTER = AW'(1 << (AW - 2));
   localparam int PIPE_DEPTH = 40;

   typedef enum int {IDLE_NONE, IDLE_SHORT, IDLE_LONG} idle_mode_type;

   typedef struct packed {
      logic signed [DW-1:0] u;
      logic signed [DW-1:0] v;
      logic                 last;
   } rotation_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [CSR_ADDR_WIDTH-1:0] paddr = '0;
   logic [CSR_DATA_WIDTH-1:0] pwdata = '0;
   logic [CSR_DATA_WIDTH-1:0] prdata;
   logic pready;
   logic req_valid = 1'b0;
   logic req_stall;
   logic signed [DW-1:0] req_u_in = '0;
   logic signed [DW-1:0] req_v_in = '0;
   logic signed [AW-1:0] req_angle = '0;
   logic req_last_sample = 1'b0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [DW-1:0] rsp_u_out;
   logic signed [DW-1:0] rsp_v_out;
   logic rsp_last_out;

   rotation_type pending_rotations[$];
   logic earth_dir = 1'b1;
   idle_mode_type src_mode = IDLE_NONE;
   idle_mode_type sink_mode = IDLE_NONE;
   int unsigned hold_req = 0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned bad_words = 0;
   int unsigned dir_writes = 0;

   wind_vector_rotation_core u_top (
      .clock(clock),
      .reset(reset),
      .psel(psel),
      .penable(penable),
      .pwrite(pwrite),
      .paddr(paddr),
      .pwdata(pwdata),
      .prdata(prdata),
      .pready(pready),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_u_in(req_u_in),
      .req_v_in(req_v_in),
      .req_angle(req_angle),
      .req_last_sample(req_last_sample),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_u_out(rsp_u_out),
      .rsp_v_out(rsp_v_out),
      .rsp_last_out(rsp_last_out)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic logic signed [DW-1:0] sat_word(input longint a);
      longint hi;
      longint lo;
      hi = (longint'(1) <<< (DW - 1)) - 1;
      lo = -hi - 1;
      if (a > hi) a = hi;
      if (a < lo) a = lo;
      return DW'(a);
   endfunction

   function automatic rotation_type rotate_wind(input logic signed [DW-1:0] u,
                                                input logic signed [DW-1:0] v,
                                                input logic signed [AW-1:0] ang,
                                                input logic last, input logic dir);
      rotation_type r;
      longint x;
      longint y;
      longint ph;
      longint sx;
      longint sy;
      longint quarter;
      quarter = longint'(1) <<< 30;
      ph = longint'(ang) <<< (32 - AW);
      if (!dir) ph = -ph;
      x = (longint'(u) * longint'(CORDIC_K) + (longint'(1) <<< (29 - GUARD_BITS)))
          >>> (30 - GUARD_BITS);
      y = (longint'(v) * longint'(CORDIC_K) + (longint'(1) <<< (29 - GUARD_BITS)))
          >>> (30 - GUARD_BITS);
      // fold into the right half-plane
      if (ph > quarter) begin
         ph = ph - 2 * quarter;
         x = -x;
         y = -y;
      end else if (ph < -quarter) begin
         ph = ph + 2 * quarter;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < CORDIC_STAGES; i++) begin
         sx = x >>> i;
         sy = y >>> i;
         if (ph >= 0) begin
            x = x - sy;
            y = y + sx;
            ph = ph - longint'(ATAN_TAB[i]);
         end else begin
            x = x + sy;
            y = y - sx;
            ph = ph + longint'(ATAN_TAB[i]);
         end
      end
      r.u = sat_word((x + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS);
      r.v = sat_word((y + (longint'(1) <<< (GUARD_BITS - 1))) >>> GUARD_BITS);
      r.last = last;
      return r;
   endfunction

   function automatic int unsigned pick_gap(input idle_mode_type mode);
      if (mode == IDLE_LONG && $urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   // receiver: random stalls, plus long holds on request
   initial begin : sink
      int unsigned run;
      int unsigned stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (hold_req != 0) begin
            run = hold_req;
            hold_req = 0;
            rsp_stall <= 1'b1;
            repeat (run) @(posedge clock);
            rsp_stall <= 1'b0;
         end else if (stall_left != 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
            if (sink_mode != IDLE_NONE && $urandom_range(0, 3) == 0)
               stall_left = pick_gap(sink_mode);
         end
      end
   end

   always @(posedge clock) begin : check_rotation
      rotation_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rotations.size() == 0) begin
            bad_words++;
            if (bad_words <= 10)
               $display("unexpected word: u %0d v %0d last %0b",
                        rsp_u_out, rsp_v_out, rsp_last_out);
         end else begin
            want = pending_rotations.pop_front();
            words_checked++;
            if (rsp_u_out !== want.u || rsp_v_out !== want.v || rsp_last_out !== want.last)
            begin
               bad_words++;
               if (bad_words <= 10)
                  $display("mismatch word %0d: u %0d/%0d v %0d/%0d last %0b/%0b (exp/act)",
                           words_checked, want.u, rsp_u_out, want.v, rsp_v_out,
                           want.last, rsp_last_out);
            end
         end
      end
   end

   task automatic send_word(input logic signed [DW-1:0] u, input logic signed [DW-1:0] v,
                            input logic signed [AW-1:0] ang, input logic last);
      int unsigned gap;
      gap = 0;
      if (src_mode != IDLE_NONE && $urandom_range(0, 2) == 0) gap = pick_gap(src_mode);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_u_in <= u;
      req_v_in <= v;
      req_angle <= ang;
      req_last_sample <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_rotations.push_back(rotate_wind(u, v, ang, last, earth_dir));
      words_sent++;
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rotations.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_ADDR_WIDTH-1:0] addr,
                            input logic [CSR_DATA_WIDTH-1:0] data);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= addr;
      pwdata <= data;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      if (addr == TO_EARTH_ADDR) begin
         earth_dir = data[0];
         dir_writes++;
      end
   endtask

   function automatic logic signed [DW-1:0] pick_component();
      case ($urandom_range(0, 9))
         0: return W_MAX;
         1: return W_MIN;
         2: return DW'($urandom_range(0, 2) - 1);
         3, 4: return DW'(int'($urandom_range(0, 4000)) - 2000);
         default: return DW'($urandom);
      endcase
   endfunction

   function automatic logic signed [AW-1:0] pick_angle();
      case ($urandom_range(0, 9))
         0: return A_MIN + AW'($urandom_range(0, 2));
         1: return A_MAX - AW'($urandom_range(0, 2));
         2: return A_QUARTER + AW'(int'($urandom_range(0, 4)) - 2);
         3: return -A_QUARTER + AW'(int'($urandom_range(0, 4)) - 2);
         4: return AW'(int'($urandom_range(0, 4)) - 2);
         default: return AW'($urandom);
      endcase
   endfunction

   task automatic test_directed;
      src_mode = IDLE_NONE;
      sink_mode = IDLE_NONE;
      send_word(0, 0, 0, 1'b0);
      send_word(W_MAX, W_MIN, 0, 1'b1);
      send_word(W_MIN, W_MAX, 0, 1'b0);
      send_word(256, 0, A_QUARTER, 1'b0);
      send_word(256, 0, AW'(A_QUARTER + 1), 1'b1);
      send_word(256, -256, -A_QUARTER, 1'b0);
      send_word(256, -256, AW'(-A_QUARTER - 1), 1'b0);
      // saturating diagonals
      send_word(W_MAX, W_MAX, AW'(A_QUARTER / 2), 1'b1);
      send_word(W_MIN, W_MIN, AW'(A_QUARTER / 2), 1'b0);
      send_word(W_MIN, W_MIN, A_MIN, 1'b1);
      send_word(1, -1, A_MAX, 1'b0);
      send_word(-1, 1, 1, 1'b1);
      send_word(123456, -654321, -1, 1'b0);
      drain();
      // unmapped register, must not change direction
      csr_write(SPARE_ADDR, '0);
      send_word(256, 512, AW'(A_QUARTER / 2), 1'b0);
      drain();
      // only bit 0 counts
      csr_write(TO_EARTH_ADDR, 32'hFFFF_FFFE);
      send_word(256, 512, AW'(A_QUARTER / 2), 1'b0);
      send_word(W_MIN, W_MIN, A_MIN, 1'b1);
      send_word(W_MAX, 0, A_QUARTER, 1'b0);
      send_word(-5000, 7000, -20000, 1'b1);
      send_word(W_MAX, W_MAX, AW'(-A_QUARTER / 2), 1'b0);
      drain();
      csr_write(TO_EARTH_ADDR, 32'h0000_0001);
   endtask

   task automatic test_random;
      for (int phase = 0; phase < 8; phase++) begin
         csr_write(TO_EARTH_ADDR, {31'($urandom), ~phase[0]});
         src_mode = idle_mode_type'(phase % 3);
         sink_mode = idle_mode_type'((phase + 1) % 3);
         repeat (80) send_word(pick_component(), pick_component(), pick_angle(), $urandom);
         drain();
      end
   endtask

   task automatic test_backpressure;
      src_mode = IDLE_NONE;
      sink_mode = IDLE_NONE;
      hold_req = 120;
      repeat (150) send_word(pick_component(), pick_component(), pick_angle(), $urandom);
      drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random();
      test_backpressure();
      drain();
      repeat (PIPE_DEPTH) @(posedge clock);
      $display("%0d rotated words checked of %0d sent, %0d direction writes, with fold,",
               words_checked, words_sent, dir_writes);
      $display("saturation and minus-pi cases under random idle and a long output hold");
      if (bad_words == 0 && pending_rotations.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
